// ===== rtl/tcp_handshake_tracker_macros.svh =====
// Assertion macros used by the handshake tracker top level.
`ifndef TCP_HANDSHAKE_TRACKER_MACROS_SVH
`define TCP_HANDSHAKE_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define THT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define THT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tht_pkg.sv =====
// Types and constants of the handshake tracker.
`default_nettype none
package tht_pkg;

  localparam logic [1:0] CMD_SYN    = 2'd0;
  localparam logic [1:0] CMD_SYNACK = 2'd1;
  localparam logic [1:0] CMD_ACK    = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [7:0]  TIMEOUT_RST = 8'd10;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  // Request token that walks the cell row.
  typedef struct packed {
    logic        vld;
    logic        pass2;   // second sweep: insert or refresh
    logic [1:0]  cmd;
    logic [31:0] key_s;   // key probed in the SYN-ACK wait table
    logic [31:0] key_a;   // key probed in the ACK wait table
    logic        hit_s;
    logic        hit_a;
    logic        done;    // insert or refresh landed
    logic [15:0] fails;   // running failure count on a tick
  } tok_t;

endpackage
`default_nettype wire

// ===== rtl/tht_cell.sv =====
// One entry of both wait tables plus its stage of the request row.
`default_nettype none
module tht_cell
  import tht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] timeout,
  input  wire tok_t       tok_in,
  output tok_t            tok_out
);

  logic [31:0] s_key_r, s_key_nxt, a_key_r, a_key_nxt;
  logic [7:0]  s_tmr_r, s_tmr_nxt, a_tmr_r, a_tmr_nxt;
  logic        s_vld_r, s_vld_nxt, a_vld_r, a_vld_nxt;
  tok_t        tok_r, tok_nxt;

  logic        s_eq, a_eq;
  logic [7:0]  s_dec, a_dec;
  logic [1:0]  inc;
  logic [16:0] fsum;

  assign s_eq  = s_vld_r && (s_key_r == tok_in.key_s);
  assign a_eq  = a_vld_r && (a_key_r == tok_in.key_a);
  assign s_dec = (s_tmr_r != 8'd0) ? s_tmr_r - 8'd1 : 8'd0;
  assign a_dec = (a_tmr_r != 8'd0) ? a_tmr_r - 8'd1 : 8'd0;
  assign inc   = {1'b0, s_vld_r && (s_dec == 8'd0)} + {1'b0, a_vld_r && (a_dec == 8'd0)};
  assign fsum  = {1'b0, tok_in.fails} + {15'd0, inc};

  always_comb begin
    s_key_nxt = s_key_r;
    s_tmr_nxt = s_tmr_r;
    s_vld_nxt = s_vld_r;
    a_key_nxt = a_key_r;
    a_tmr_nxt = a_tmr_r;
    a_vld_nxt = a_vld_r;
    tok_nxt   = tok_in;
    if (tok_in.vld) begin
      if (!tok_in.pass2) begin
        unique case (tok_in.cmd)
          CMD_SYN: begin
            if (s_eq) tok_nxt.hit_s = 1'b1;
          end
          CMD_SYNACK: begin
            // drop the matching SYN-ACK wait entry, probe the ACK table for the new key
            if (s_eq && !tok_in.hit_s) begin
              s_vld_nxt     = 1'b0;
              tok_nxt.hit_s = 1'b1;
            end
            if (a_eq) tok_nxt.hit_a = 1'b1;
          end
          CMD_ACK: begin
            if (a_eq && !tok_in.hit_a) begin
              a_vld_nxt     = 1'b0;
              tok_nxt.hit_a = 1'b1;
            end
          end
          default: begin
            // tick: age both entries, drop and count expired ones
            if (s_vld_r) begin
              s_tmr_nxt = s_dec;
              if (s_dec == 8'd0) s_vld_nxt = 1'b0;
            end
            if (a_vld_r) begin
              a_tmr_nxt = a_dec;
              if (a_dec == 8'd0) a_vld_nxt = 1'b0;
            end
            tok_nxt.fails = fsum[16] ? COUNT_MAX : fsum[15:0];
          end
        endcase
      end else if (tok_in.cmd == CMD_SYN) begin
        if (tok_in.hit_s) begin
          if (s_eq) begin
            s_tmr_nxt    = timeout;
            tok_nxt.done = 1'b1;
          end
        end else if (!tok_in.done && !s_vld_r) begin
          s_key_nxt    = tok_in.key_s;
          s_tmr_nxt    = timeout;
          s_vld_nxt    = 1'b1;
          tok_nxt.done = 1'b1;
        end
      end else begin
        if (tok_in.hit_a) begin
          if (a_eq) begin
            a_tmr_nxt    = timeout;
            tok_nxt.done = 1'b1;
          end
        end else if (!tok_in.done && !a_vld_r) begin
          a_key_nxt    = tok_in.key_a;
          a_tmr_nxt    = timeout;
          a_vld_nxt    = 1'b1;
          tok_nxt.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s_key_r <= s_key_nxt;
    a_key_r <= a_key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_tmr_r   <= 8'd0;
      s_vld_r   <= 1'b0;
      a_tmr_r   <= 8'd0;
      a_vld_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      s_tmr_r <= s_tmr_nxt;
      s_vld_r <= s_vld_nxt;
      a_tmr_r <= a_tmr_nxt;
      a_vld_r <= a_vld_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

// ===== rtl/tcp_handshake_tracker.sv =====
// Top level of the TCP handshake tracker: command control and the cell row.
// Each request walks a row of WAIT_ENTRIES cells, one cell a cycle; every cell
// holds one SYN-ACK wait entry and one ACK wait entry. ACK, tick and unmatched
// SYN-ACK requests take one sweep; SYN and matched SYN-ACK requests take a lookup
// sweep and an insert sweep. start is taken only while idle, so a new request
// waits for the previous one to finish; busy is high until the result strobe.
// Each request yields exactly one result, shown for one cycle with out_valid;
// the receiver cannot stall it. Write cfg_wdata only while busy is low.
`default_nettype none
`include "tcp_handshake_tracker_macros.svh"
module tcp_handshake_tracker
  import tht_pkg::*;
#(
  parameter int WAIT_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_seq_num,
  input  wire logic [31:0] in_ack_num,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  output logic             out_valid,
  output logic             out_matched,
  output logic             out_table_full,
  output logic             out_report_valid,
  output logic [15:0]      out_success_count,
  output logic [15:0]      out_fail_count
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PASS1 = 2'd1;
  localparam logic [1:0] ST_PASS2 = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  timeout_r;
  logic [15:0] succ_r, succ_nxt, fail_r, fail_nxt;
  tok_t        inj_r, inj_nxt;
  tok_t        link [0:WAIT_ENTRIES];
  tok_t        tail;

  logic        ov_r, ov_nxt;
  logic        om_r, om_nxt, of_r, of_nxt, orv_r, orv_nxt;
  logic [15:0] osc_r, osc_nxt, ofc_r, ofc_nxt;

  assign link[0] = inj_r;
  assign tail    = link[WAIT_ENTRIES];

  for (genvar g = 0; g < WAIT_ENTRIES; g++) begin : g_cell
    tht_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .timeout (timeout_r),
      .tok_in  (link[g]),
      .tok_out (link[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    inj_nxt     = inj_r;
    inj_nxt.vld = 1'b0;
    succ_nxt  = succ_r;
    fail_nxt  = fail_r;
    ov_nxt    = 1'b0;
    om_nxt    = 1'b0;
    of_nxt    = 1'b0;
    orv_nxt   = 1'b0;
    osc_nxt   = 16'd0;
    ofc_nxt   = 16'd0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          inj_nxt.vld   = 1'b1;
          inj_nxt.pass2 = 1'b0;
          inj_nxt.cmd   = in_cmd;
          inj_nxt.key_s = (in_cmd == CMD_SYN) ? in_seq_num + 32'd1 : in_ack_num;
          inj_nxt.key_a = (in_cmd == CMD_SYNACK) ? in_seq_num + 32'd1 : in_ack_num;
          inj_nxt.hit_s = 1'b0;
          inj_nxt.hit_a = 1'b0;
          inj_nxt.done  = 1'b0;
          inj_nxt.fails = 16'd0;
          state_nxt     = ST_PASS1;
        end
      end
      ST_PASS1, ST_PASS2: begin
        if (tail.vld) begin
          if (state_r == ST_PASS1 &&
              (tail.cmd == CMD_SYN || (tail.cmd == CMD_SYNACK && tail.hit_s))) begin
            // rerun the row to insert or refresh the new key
            inj_nxt       = tail;
            inj_nxt.pass2 = 1'b1;
            state_nxt     = ST_PASS2;
          end else begin
            ov_nxt    = 1'b1;
            om_nxt    = (tail.cmd == CMD_SYNACK && tail.hit_s) ||
                        (tail.cmd == CMD_ACK && tail.hit_a);
            of_nxt    = tail.pass2 && !tail.done;
            state_nxt = ST_IDLE;
            if (tail.cmd == CMD_TICK) begin
              orv_nxt  = 1'b1;
              osc_nxt  = succ_r;
              ofc_nxt  = fail_r;
              succ_nxt = 16'd0;
              fail_nxt = tail.fails;
            end else if (tail.cmd == CMD_ACK && tail.hit_a && succ_r != COUNT_MAX) begin
              succ_nxt = succ_r + 16'd1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      timeout_r <= TIMEOUT_RST;
      succ_r    <= 16'd0;
      fail_r    <= 16'd0;
      inj_r.vld <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      succ_r  <= succ_nxt;
      fail_r  <= fail_nxt;
      inj_r   <= inj_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    om_r  <= om_nxt;
    of_r  <= of_nxt;
    orv_r <= orv_nxt;
    osc_r <= osc_nxt;
    ofc_r <= ofc_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = ov_r;
  assign out_matched       = om_r;
  assign out_table_full    = of_r;
  assign out_report_valid  = orv_r;
  assign out_success_count = osc_r;
  assign out_fail_count    = ofc_r;

  `THT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `THT_ASSERT_NOW(a_result_idle, ov_r, !busy, "result strobe while still busy")
  `THT_ASSERT_NOW(a_tail_busy, tail.vld, busy, "token left the row while idle")
  `THT_ASSERT_NOW(a_report_clean, ov_r && orv_r, !om_r && !of_r,
                  "tick result carries match or full flag")

endmodule
`default_nettype wire

// ===== sim/tb_tcp_handshake_tracker.sv =====
// Self-checking testbench for the TCP handshake tracker: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_tcp_handshake_tracker;
  import tht_pkg::*;

  localparam int N_WAIT      = 16;
  localparam int TBL_SYNACK  = 0;
  localparam int TBL_ACK     = 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        matched;
    logic        table_full;
    logic        report_valid;
    logic [15:0] success_count;
    logic [15:0] fail_count;
  } hs_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] seq;
    logic [31:0] ack;
    bit          typed;
    hs_result_t  res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [31:0] in_seq_num;
  logic [31:0] in_ack_num;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        out_valid;
  logic        out_matched;
  logic        out_table_full;
  logic        out_report_valid;
  logic [15:0] out_success_count;
  logic [15:0] out_fail_count;

  tcp_handshake_tracker #(.WAIT_ENTRIES(N_WAIT)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_seq_num       (in_seq_num),
    .in_ack_num       (in_ack_num),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_matched      (out_matched),
    .out_table_full   (out_table_full),
    .out_report_valid (out_report_valid),
    .out_success_count(out_success_count),
    .out_fail_count   (out_fail_count)
  );

  // Shadow of the tracker state
  logic [31:0] wait_key   [2][N_WAIT];
  logic [7:0]  wait_timer [2][N_WAIT];
  bit          wait_vld   [2][N_WAIT];
  logic [7:0]  timeout_reg;
  logic [15:0] succ_cnt;
  logic [15:0] fail_cnt;

  hs_result_t pending_results[$];
  stim_row_t  directed_rows[$];

  int mismatches;
  int requests_sent;
  int ticks_sent;
  int results_seen;
  int matches_seen;
  int full_seen;
  int cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int find_entry(int t, logic [31:0] key);
    for (int i = 0; i < N_WAIT; i++)
      if (wait_vld[t][i] && wait_key[t][i] == key) return i;
    return -1;
  endfunction

  // Refresh a matching key in place, else take the lowest free slot.
  function automatic bit put_entry(int t, logic [31:0] key);
    int i;
    i = find_entry(t, key);
    if (i < 0) begin
      i = 0;
      while (i < N_WAIT && wait_vld[t][i]) i++;
      if (i == N_WAIT) return 1'b1;
    end
    wait_key[t][i]   = key;
    wait_timer[t][i] = timeout_reg;
    wait_vld[t][i]   = 1'b1;
    return 1'b0;
  endfunction

  function automatic void age_table(int t);
    for (int i = 0; i < N_WAIT; i++) begin
      if (wait_vld[t][i]) begin
        if (wait_timer[t][i] != 8'd0) wait_timer[t][i]--;
        if (wait_timer[t][i] == 8'd0) begin
          wait_vld[t][i] = 1'b0;
          if (fail_cnt != COUNT_MAX) fail_cnt++;
        end
      end
    end
  endfunction

  function automatic hs_result_t track_segment(logic [1:0] cmd, logic [31:0] seq,
                                               logic [31:0] ack);
    hs_result_t r;
    int i;
    r = '0;
    case (cmd)
      CMD_SYN: begin
        r.table_full = put_entry(TBL_SYNACK, seq + 32'd1);
      end
      CMD_SYNACK: begin
        i = find_entry(TBL_SYNACK, ack);
        if (i >= 0) begin
          wait_vld[TBL_SYNACK][i] = 1'b0;
          r.matched    = 1'b1;
          r.table_full = put_entry(TBL_ACK, seq + 32'd1);
        end
      end
      CMD_ACK: begin
        i = find_entry(TBL_ACK, ack);
        if (i >= 0) begin
          wait_vld[TBL_ACK][i] = 1'b0;
          r.matched = 1'b1;
          if (succ_cnt != COUNT_MAX) succ_cnt++;
        end
      end
      default: begin
        r.report_valid  = 1'b1;
        r.success_count = succ_cnt;
        r.fail_count    = fail_cnt;
        succ_cnt = '0;
        fail_cnt = '0;
        age_table(TBL_SYNACK);
        age_table(TBL_ACK);
      end
    endcase
    return r;
  endfunction

  // Pick the key of a random waiting entry, or the fallback if the table is empty.
  function automatic logic [31:0] pick_waiting_key(int t, logic [31:0] fallback);
    int n;
    int sel;
    n = 0;
    for (int i = 0; i < N_WAIT; i++) if (wait_vld[t][i]) n++;
    if (n == 0) return fallback;
    sel = $urandom_range(n - 1);
    for (int i = 0; i < N_WAIT; i++) begin
      if (wait_vld[t][i]) begin
        if (sel == 0) return wait_key[t][i];
        sel--;
      end
    end
    return fallback;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    hs_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_matched === 1'b1) matches_seen++;
      if (out_table_full === 1'b1) full_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %0h_%0h_%0h_%0h_%0h", $time,
                 out_matched, out_table_full, out_report_valid, out_success_count,
                 out_fail_count);
      end else begin
        want = pending_results.pop_front();
        check_field("matched", want.matched, out_matched);
        check_field("table_full", want.table_full, out_table_full);
        check_field("report_valid", want.report_valid, out_report_valid);
        check_field("success_count", want.success_count, out_success_count);
        check_field("fail_count", want.fail_count, out_fail_count);
      end
    end
  end

  // Present one request; optionally idle or drain first. Returns the shadow's result.
  task automatic send_segment(input logic [1:0] cmd, input logic [31:0] seq,
                              input logic [31:0] ack, input bit typed,
                              input hs_result_t want, input int gap, input bit drain,
                              output hs_result_t got);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      if (drain) begin
        while (pending_results.size() != 0) @(posedge clk);
        if (gap == 0) gap = 1;
      end
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_seq_num <= seq;
    in_ack_num <= ack;
    do @(posedge clk); while (busy);
    got = track_segment(cmd, seq, ack);
    pending_results.push_back(typed ? want : got);
    requests_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
  endtask

  task automatic write_timeout(input logic [7:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    timeout_reg = value;
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [31:0] seq,
                         input logic [31:0] ack, input bit typed, input hs_result_t res);
    stim_row_t row;
    row.cmd   = cmd;
    row.seq   = seq;
    row.ack   = ack;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  // Mostly well-formed handshakes built from waiting keys, with some noise.
  task automatic run_random(input int n_items, input int idle_pct, input bit fill_bias);
    int counted;
    int roll;
    int gap;
    bit drain;
    bit drained;
    logic [1:0]  cmd;
    logic [31:0] seq;
    logic [31:0] ack;
    hs_result_t  got;
    counted = 0;
    drained = 1'b0;
    while (counted < n_items) begin
      roll = $urandom_range(99);
      seq  = $urandom;
      ack  = $urandom;
      if (fill_bias) begin
        if (roll < 45)      cmd = CMD_SYN;
        else if (roll < 85) cmd = CMD_SYNACK;
        else if (roll < 90) cmd = CMD_ACK;
        else if (roll < 93) cmd = CMD_TICK;
        else                cmd = 2'($urandom_range(3));
      end else begin
        if (roll < 30)      cmd = CMD_SYN;
        else if (roll < 55) cmd = CMD_SYNACK;
        else if (roll < 77) cmd = CMD_ACK;
        else if (roll < 87) cmd = CMD_TICK;
        else                cmd = 2'($urandom_range(3));
      end
      if (roll < 87) begin
        case (cmd)
          CMD_SYN: begin
            roll = $urandom_range(99);
            if (roll < 5)       seq = 32'h0000_0000;
            else if (roll < 10) seq = 32'hFFFF_FFFF;
            else if (roll < 20) seq = pick_waiting_key(TBL_SYNACK, seq) - 32'd1;
          end
          CMD_SYNACK: if ($urandom_range(99) < 85) ack = pick_waiting_key(TBL_SYNACK, ack);
          CMD_ACK:    if ($urandom_range(99) < 85) ack = pick_waiting_key(TBL_ACK, ack);
          default: ;
        endcase
      end
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 40) : 0;
      drain = !drained && counted >= n_items / 2;
      if (drain) drained = 1'b1;
      send_segment(cmd, seq, ack, 1'b0, '0, gap, drain, got);
      counted++;
    end
  endtask

  initial begin
    hs_result_t res;
    hs_result_t got;
    logic [7:0] last_timeout;
    int gap;

    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_cmd     <= CMD_SYN;
    in_seq_num <= '0;
    in_ack_num <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    mismatches    = 0;
    requests_sent = 0;
    ticks_sent    = 0;
    results_seen  = 0;
    matches_seen  = 0;
    full_seen     = 0;
    cycle_cnt     = 0;
    timeout_reg   = TIMEOUT_RST;
    succ_cnt      = '0;
    fail_cnt      = '0;
    for (int t = 0; t < 2; t++)
      for (int i = 0; i < N_WAIT; i++) begin
        wait_key[t][i]   = '0;
        wait_timer[t][i] = '0;
        wait_vld[t][i]   = 1'b0;
      end

    // Directed: empty-table report, misses, sequence wrap, refresh, full table.
    res = '0; res.report_valid = 1'b1;
    add_row(CMD_TICK, 32'h0, 32'h0, 1'b1, res);
    res = '0;
    add_row(CMD_ACK, 32'h0, 32'h0, 1'b1, res);
    add_row(CMD_SYNACK, 32'h0, 32'hFFFF_FFFF, 1'b1, res);
    add_row(CMD_SYN, 32'hFFFF_FFFF, 32'h0, 1'b1, res);
    res.matched = 1'b1;
    add_row(CMD_SYNACK, 32'hFFFF_FFFF, 32'h0, 1'b1, res);
    add_row(CMD_ACK, 32'hFFFF_FFFF, 32'h0, 1'b1, res);
    res = '0; res.report_valid = 1'b1; res.success_count = 16'd1;
    add_row(CMD_TICK, 32'h0, 32'hFFFF_FFFF, 1'b1, res);
    add_row(CMD_SYN, 32'h0, 32'h0, 1'b0, '0);
    add_row(CMD_SYN, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
    for (int i = 0; i < N_WAIT - 1; i++)
      add_row(CMD_SYN, 32'h8000_0000 + i, $urandom, 1'b0, '0);
    res = '0; res.table_full = 1'b1;
    add_row(CMD_SYN, 32'h1234_5678, 32'h0, 1'b1, res);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      gap = ($urandom_range(99) < 36) ? $urandom_range(1, 40) : 0;
      send_segment(directed_rows[k].cmd, directed_rows[k].seq, directed_rows[k].ack,
                   directed_rows[k].typed, directed_rows[k].res, gap, 1'b0, got);
    end

    write_timeout(8'd1);
    run_random(125, 36, 1'b0);
    // Long timeout with few acks and ticks: let both tables fill up.
    write_timeout(8'd255);
    run_random(125, 73, 1'b1);
    write_timeout(8'd0);
    run_random(125, 0, 1'b0);
    last_timeout = 8'($urandom_range(2, 12));
    write_timeout(last_timeout);
    run_random(125, 36, 1'b0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d ticks) with timeouts 10, 1, 255, 0 and %0d", requests_sent,
             ticks_sent, last_timeout);
    $display("Checked %0d results: %0d matched, %0d dropped on a full table", results_seen,
             matches_seen, full_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
